// File: design/cbam_pkg.sv
`default_nettype none
package cbam_pkg;

    localparam int ROM_ADDR_BITS_DEF = 22;
    localparam int ADDR_MAX_W        = 24;

    localparam int PROGRAM_SLOTS = 4;
    localparam int PATTERN_SLOTS = 8;
    localparam int PRG_IDX_W     = $clog2(PROGRAM_SLOTS);
    localparam int PAT_IDX_W     = $clog2(PATTERN_SLOTS);

    localparam int SIZE_W      = 23;
    localparam int OFFSET_W    = 22;
    localparam int ADDR_W      = 16;
    localparam int KB_W        = 6;
    localparam int SLOT_W      = 3;
    localparam int BANK_W      = 16;
    localparam int BANK_ADJ_W  = 18;
    localparam int ITER_W      = 4;
    localparam int PROD_W      = KB_W + 1 + BANK_ADJ_W;
    localparam int V_W         = PROD_W + 10;
    localparam int DIV_W       = V_W - 1;
    localparam int QUO_W       = SIZE_W - 10;

    localparam int PRG_SLOT_SHIFT = 13;
    localparam int PAT_SLOT_SHIFT = 10;

    localparam logic [ADDR_W-1:0] WRAM_BASE = 16'h6000;
    localparam logic [ADDR_W-1:0] PRG_BASE  = 16'h8000;

    localparam logic [SIZE_W-1:0] PRG_ROM_RESET = 23'd32768;
    localparam logic [SIZE_W-1:0] PAT_RESET     = 23'd8192;

    typedef enum logic [1:0] {
        KIND_CPU_READ    = 2'd0,
        KIND_PPU_READ    = 2'd1,
        KIND_MAP_PROGRAM = 2'd2,
        KIND_MAP_PATTERN = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        REGION_UNMAPPED = 3'd0,
        REGION_WORK_RAM = 3'd1,
        REGION_PROGRAM  = 3'd2,
        REGION_PATTERN  = 3'd3,
        REGION_MAP_DONE = 3'd4
    } region_t;

    typedef enum logic {
        CFG_PROGRAM_ROM_BYTES = 1'b0,
        CFG_PATTERN_BYTES     = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV_QUO,
        ST_MUL,
        ST_CHECK,
        ST_MOD_START,
        ST_MOD_WAIT,
        ST_WRITE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_item;
        logic quo_start;
        logic bank_adjust;
        logic mul;
        logic sum;
        logic mod_start;
        logic slot_write;
        logic emit;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  map_empty;
        logic  bank_neg;
        logic  slot_ok;
        logic  div_done;
        logic  out_free;
    } status_t;

endpackage
`default_nettype wire

// File: design/cbam_div.sv
`default_nettype none
module cbam_div (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic [cbam_pkg::DIV_W-1:0]      dividend,
    input  wire logic [cbam_pkg::SIZE_W-1:0]     divisor,
    output logic                                 done,
    output logic [cbam_pkg::DIV_W-1:0]           quotient,
    output logic [cbam_pkg::SIZE_W-1:0]          remainder
);
    localparam int CNT_W = $clog2(cbam_pkg::DIV_W + 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [cbam_pkg::DIV_W-1:0]    dvd_reg;
    logic [cbam_pkg::SIZE_W-1:0]   rem_reg;
    logic [cbam_pkg::SIZE_W-1:0]   divisor_reg;

    logic [cbam_pkg::SIZE_W:0]     trial;
    logic [cbam_pkg::SIZE_W:0]     diff;
    logic                          fits;
    logic [cbam_pkg::SIZE_W-1:0]   rem_next;
    logic [cbam_pkg::DIV_W-1:0]    dvd_next;

    // Restoring division, one quotient bit per cycle; quotient bits shift in
    // behind the dividend bits as they leave.
    always_comb begin
        trial    = {rem_reg, dvd_reg[cbam_pkg::DIV_W-1]};
        diff     = trial - {1'b0, divisor_reg};
        fits     = (trial >= {1'b0, divisor_reg});
        rem_next = fits ? diff[cbam_pkg::SIZE_W-1:0] : trial[cbam_pkg::SIZE_W-1:0];
        dvd_next = {dvd_reg[cbam_pkg::DIV_W-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else if (start) begin
            busy_reg    <= 1'b1;
            done_reg    <= 1'b0;
            count_reg   <= CNT_W'(cbam_pkg::DIV_W);
            dvd_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end else if (busy_reg) begin
            dvd_reg   <= dvd_next;
            rem_reg   <= rem_next;
            count_reg <= count_reg - 1'b1;
            if (count_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

// File: design/cbam_datapath.sv
`default_nettype none
module cbam_datapath #(
    parameter int ROM_ADDR_BITS = cbam_pkg::ROM_ADDR_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire cbam_pkg::cmd_t                    cmd,
    output cbam_pkg::status_t                      status,
    input  wire logic [1:0]                        in_kind,
    input  wire logic [cbam_pkg::ADDR_W-1:0]       in_address,
    input  wire logic [cbam_pkg::KB_W-1:0]         in_bank_kb,
    input  wire logic [cbam_pkg::SLOT_W-1:0]       in_slot,
    input  wire logic [cbam_pkg::BANK_W-1:0]       in_bank_number,
    input  wire logic                              cfg_valid,
    input  wire logic                              cfg_index,
    input  wire logic [cbam_pkg::SIZE_W-1:0]       cfg_data,
    input  wire logic                              m_ready,
    output logic                                   m_valid,
    output logic [2:0]                             m_region,
    output logic [cbam_pkg::OFFSET_W-1:0]          m_offset
);
    localparam int SW = cbam_pkg::SIZE_W;
    localparam int VW = cbam_pkg::V_W;

    cbam_pkg::kind_t                       kind_reg;
    logic [cbam_pkg::ADDR_W-1:0]           addr_reg;
    logic [cbam_pkg::KB_W-1:0]             kb_reg;
    logic [cbam_pkg::SLOT_W-1:0]           slot_reg;
    logic signed [cbam_pkg::BANK_ADJ_W-1:0] bank_reg;
    logic signed [VW-1:0]                  base_reg;
    logic signed [VW-1:0]                  v_reg;
    logic [cbam_pkg::ITER_W-1:0]           i_reg;
    logic [SW-1:0]                         prg_bytes_reg;
    logic [SW-1:0]                         pat_bytes_reg;
    logic [ROM_ADDR_BITS-1:0]              prg_tab_reg [cbam_pkg::PROGRAM_SLOTS];
    logic [ROM_ADDR_BITS-1:0]              pat_tab_reg [cbam_pkg::PATTERN_SLOTS];
    logic                                  out_valid_reg;
    logic [2:0]                            out_region_reg;
    logic [cbam_pkg::OFFSET_W-1:0]         out_offset_reg;

    logic [2:0]                            prg_count;
    logic [5:0]                            prg_first;
    logic [6:0]                            prg_idx;
    logic [8:0]                            pat_first;
    logic [9:0]                            pat_idx;
    logic                                  is_program;
    logic [SW-1:0]                         modulus;

    logic signed [cbam_pkg::PROD_W-1:0]    prod;
    logic signed [VW-1:0]                  base_next;
    logic [VW-1:0]                         step_term;
    logic signed [VW-1:0]                  v_next;
    logic [VW-1:0]                         v_mag;
    logic signed [cbam_pkg::BANK_ADJ_W-1:0] bank_next;

    logic                                  div_start;
    logic [cbam_pkg::DIV_W-1:0]            div_dividend;
    logic [SW-1:0]                         div_divisor;
    logic                                  div_done;
    logic [cbam_pkg::DIV_W-1:0]            div_quo;
    logic [SW-1:0]                         div_rem;

    logic [SW-1:0]                         mod_fixed;
    logic [cbam_pkg::ADDR_MAX_W-1:0]       mod_ext;
    logic [ROM_ADDR_BITS-1:0]              store_value;

    logic [ROM_ADDR_BITS-1:0]              prg_sum;
    logic [ROM_ADDR_BITS-1:0]              pat_sum;
    logic [cbam_pkg::ADDR_MAX_W-1:0]       prg_sum_ext;
    logic [cbam_pkg::ADDR_MAX_W-1:0]       pat_sum_ext;
    logic [2:0]                            region_next;
    logic [cbam_pkg::OFFSET_W-1:0]         offset_next;

    always_comb begin
        is_program = (kind_reg == cbam_pkg::KIND_MAP_PROGRAM);
        modulus    = is_program ? prg_bytes_reg : pat_bytes_reg;

        // Program banks cover bank_kb/8 slots of 8 KB, pattern banks bank_kb
        // slots of 1 KB, starting at slot times that count.
        prg_count = kb_reg[5:3];
        prg_first = {3'b0, prg_count} * {3'b0, slot_reg};
        prg_idx   = 7'(prg_first) + 7'(i_reg);
        pat_first = {3'b0, kb_reg} * {6'b0, slot_reg};
        pat_idx   = 10'(pat_first) + 10'(i_reg);

        status.kind     = kind_reg;
        status.bank_neg = bank_reg[cbam_pkg::BANK_ADJ_W-1];
        status.div_done = div_done;
        status.out_free = !out_valid_reg || m_ready;
        if (is_program) begin
            status.map_empty = (prg_count == 3'd0);
            status.slot_ok   = (i_reg < {1'b0, prg_count}) &&
                               (prg_idx < 7'(cbam_pkg::PROGRAM_SLOTS));
        end else begin
            status.map_empty = (kb_reg == '0);
            status.slot_ok   = ({2'b0, i_reg} < kb_reg) &&
                               (pat_idx < 10'(cbam_pkg::PATTERN_SLOTS));
        end
    end

    always_comb begin
        prod      = $signed({1'b0, kb_reg}) * bank_reg;
        base_next = {prod, 10'b0};
        step_term = is_program ? (VW'(i_reg) << cbam_pkg::PRG_SLOT_SHIFT)
                               : (VW'(i_reg) << cbam_pkg::PAT_SLOT_SHIFT);
        v_next    = base_reg + $signed(step_term);
        v_mag     = v_reg[VW-1] ? VW'(-v_reg) : VW'(v_reg);
        bank_next = bank_reg + $signed({5'b0, div_quo[cbam_pkg::QUO_W-1:0]});
    end

    // The divider serves both the bank count of a negative program bank and
    // the modulo of every slot offset.
    always_comb begin
        div_start = cmd.quo_start || cmd.mod_start;
        if (cmd.quo_start) begin
            div_dividend = cbam_pkg::DIV_W'(prg_bytes_reg[SW-1:10]);
            div_divisor  = SW'(kb_reg);
        end else begin
            div_dividend = v_mag[cbam_pkg::DIV_W-1:0];
            div_divisor  = modulus;
        end
    end

    cbam_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // A negative value with a nonzero remainder folds back into range.
    always_comb begin
        if (modulus == '0) begin
            mod_fixed = '0;
        end else if (v_reg[VW-1] && (div_rem != '0)) begin
            mod_fixed = modulus - div_rem;
        end else begin
            mod_fixed = div_rem;
        end
        mod_ext     = cbam_pkg::ADDR_MAX_W'(mod_fixed);
        store_value = mod_ext[ROM_ADDR_BITS-1:0];
    end

    always_comb begin
        prg_sum = prg_tab_reg[addr_reg[14:13]] + ROM_ADDR_BITS'(addr_reg[12:0]);
        pat_sum = pat_tab_reg[addr_reg[12:10]] + ROM_ADDR_BITS'(addr_reg[9:0]);
        prg_sum_ext = cbam_pkg::ADDR_MAX_W'(prg_sum);
        pat_sum_ext = cbam_pkg::ADDR_MAX_W'(pat_sum);
        region_next = cbam_pkg::REGION_MAP_DONE;
        offset_next = '0;
        case (kind_reg)
            cbam_pkg::KIND_CPU_READ: begin
                if (addr_reg < cbam_pkg::WRAM_BASE) begin
                    region_next = cbam_pkg::REGION_UNMAPPED;
                end else if (addr_reg < cbam_pkg::PRG_BASE) begin
                    region_next = cbam_pkg::REGION_WORK_RAM;
                    offset_next = cbam_pkg::OFFSET_W'(addr_reg[12:0]);
                end else begin
                    region_next = cbam_pkg::REGION_PROGRAM;
                    offset_next = prg_sum_ext[cbam_pkg::OFFSET_W-1:0];
                end
            end
            cbam_pkg::KIND_PPU_READ: begin
                region_next = cbam_pkg::REGION_PATTERN;
                offset_next = pat_sum_ext[cbam_pkg::OFFSET_W-1:0];
            end
            default: begin
                region_next = cbam_pkg::REGION_MAP_DONE;
                offset_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            kind_reg <= cbam_pkg::kind_t'(in_kind);
            addr_reg <= in_address;
            kb_reg   <= in_bank_kb;
            slot_reg <= in_slot;
            bank_reg <= cbam_pkg::BANK_ADJ_W'($signed(in_bank_number));
        end else if (cmd.bank_adjust) begin
            bank_reg <= bank_next;
        end
        if (cmd.mul) begin
            base_reg <= base_next;
        end
        if (cmd.sum) begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_reg         <= '0;
            prg_bytes_reg <= cbam_pkg::PRG_ROM_RESET;
            pat_bytes_reg <= cbam_pkg::PAT_RESET;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < cbam_pkg::PROGRAM_SLOTS; k++) begin
                prg_tab_reg[k] <= '0;
            end
            for (int k = 0; k < cbam_pkg::PATTERN_SLOTS; k++) begin
                pat_tab_reg[k] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                if (cfg_index == cbam_pkg::CFG_PROGRAM_ROM_BYTES) begin
                    prg_bytes_reg <= cfg_data;
                end else begin
                    pat_bytes_reg <= cfg_data;
                end
            end
            if (cmd.mul) begin
                i_reg <= '0;
            end else if (cmd.slot_write) begin
                i_reg <= i_reg + 1'b1;
                if (is_program) begin
                    prg_tab_reg[prg_idx[cbam_pkg::PRG_IDX_W-1:0]] <= store_value;
                end else begin
                    pat_tab_reg[pat_idx[cbam_pkg::PAT_IDX_W-1:0]] <= store_value;
                end
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_region_reg <= region_next;
            out_offset_reg <= offset_next;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_region = out_region_reg;
    assign m_offset = out_offset_reg;

endmodule
`default_nettype wire

// File: design/cbam_ctrl.sv
`default_nettype none
module cbam_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire cbam_pkg::status_t   status,
    output cbam_pkg::cmd_t           cmd
);
    cbam_pkg::state_t state_reg;
    cbam_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cbam_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            cbam_pkg::ST_IDLE: begin
                // No word is taken while reset is held.
                s_ready = aresetn;
                if (s_valid && aresetn) begin
                    cmd.load_item = 1'b1;
                    state_next    = cbam_pkg::ST_DECODE;
                end
            end
            cbam_pkg::ST_DECODE: begin
                unique case (status.kind)
                    cbam_pkg::KIND_CPU_READ,
                    cbam_pkg::KIND_PPU_READ: begin
                        state_next = cbam_pkg::ST_EMIT;
                    end
                    cbam_pkg::KIND_MAP_PROGRAM: begin
                        if (status.map_empty) begin
                            state_next = cbam_pkg::ST_EMIT;
                        end else if (status.bank_neg) begin
                            cmd.quo_start = 1'b1;
                            state_next    = cbam_pkg::ST_DIV_QUO;
                        end else begin
                            state_next = cbam_pkg::ST_MUL;
                        end
                    end
                    cbam_pkg::KIND_MAP_PATTERN: begin
                        if (status.map_empty) begin
                            state_next = cbam_pkg::ST_EMIT;
                        end else begin
                            state_next = cbam_pkg::ST_MUL;
                        end
                    end
                    default: begin
                        state_next = cbam_pkg::ST_EMIT;
                    end
                endcase
            end
            cbam_pkg::ST_DIV_QUO: begin
                if (status.div_done) begin
                    cmd.bank_adjust = 1'b1;
                    state_next      = cbam_pkg::ST_MUL;
                end
            end
            cbam_pkg::ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = cbam_pkg::ST_CHECK;
            end
            cbam_pkg::ST_CHECK: begin
                if (status.slot_ok) begin
                    cmd.sum    = 1'b1;
                    state_next = cbam_pkg::ST_MOD_START;
                end else begin
                    state_next = cbam_pkg::ST_EMIT;
                end
            end
            cbam_pkg::ST_MOD_START: begin
                cmd.mod_start = 1'b1;
                state_next    = cbam_pkg::ST_MOD_WAIT;
            end
            cbam_pkg::ST_MOD_WAIT: begin
                if (status.div_done) begin
                    state_next = cbam_pkg::ST_WRITE;
                end
            end
            cbam_pkg::ST_WRITE: begin
                cmd.slot_write = 1'b1;
                state_next     = cbam_pkg::ST_CHECK;
            end
            cbam_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = cbam_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cbam_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: design/cartridge_bank_address_mapper_unit.sv
// Cartridge bank address mapper. Each input word is a CPU read, a PPU read or
// a bank map command, and each yields exactly one output word: a region code
// in m_axis_tuser and a byte offset in m_axis_tdata. A read passes through
// DECODE to EMIT, where the result is registered, and the next word can be
// accepted on the cycle after the result is loaded, even if it has not yet
// been taken. Map commands run through a single 34-step restoring divider
// that computes every slot offset modulo the memory size: after DECODE and
// MUL, each slot written takes CHECK, MOD_START, MOD_WAIT and WRITE, and a
// negative program bank needs the bank count of the ROM (DIV_QUO) before MUL.
// The size registers are written through the cfg port (index 0 program ROM
// bytes, index 1 pattern bytes), which is ready whenever reset is released
// and should only be used while the block is idle.
`default_nettype none
module cartridge_bank_address_mapper_unit #(
    parameter int ROM_ADDR_BITS = cbam_pkg::ROM_ADDR_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // address[15:0], bank_kb[21:16], slot[24:22], bank_number[40:25], zero pad
    input  wire logic [47:0] s_axis_tdata,
    // kind[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // offset[21:0], zero pad
    output logic [23:0]      m_axis_tdata,
    // region[2:0]
    output logic [2:0]       m_axis_tuser,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [22:0] cfg_data
);
    cbam_pkg::cmd_t                 cmd;
    cbam_pkg::status_t              status;
    logic [cbam_pkg::OFFSET_W-1:0]  offset;

    cbam_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .status  (status),
        .cmd     (cmd)
    );

    cbam_datapath #(
        .ROM_ADDR_BITS (ROM_ADDR_BITS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .in_kind        (s_axis_tuser),
        .in_address     (s_axis_tdata[15:0]),
        .in_bank_kb     (s_axis_tdata[21:16]),
        .in_slot        (s_axis_tdata[24:22]),
        .in_bank_number (s_axis_tdata[40:25]),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .m_ready        (m_axis_tready),
        .m_valid        (m_axis_tvalid),
        .m_region       (m_axis_tuser),
        .m_offset       (offset)
    );

    assign m_axis_tdata = {2'b00, offset};
    assign cfg_ready    = aresetn;

`ifndef SYNTHESIS
    // Only one word is in work at a time.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a word is still in work");

    a_map_zero_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && ((m_axis_tuser == cbam_pkg::REGION_MAP_DONE) ||
                           (m_axis_tuser == cbam_pkg::REGION_UNMAPPED)))
        |-> (m_axis_tdata == '0))
        else $error("map done or unmapped word carries a nonzero offset");

    a_wram_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tuser == cbam_pkg::REGION_WORK_RAM))
        |-> (m_axis_tdata[23:13] == '0))
        else $error("work RAM offset beyond 8 KB");
`endif

endmodule
`default_nettype wire
